// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the parenthesis balance checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pbc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbc_pkg
// Types and constants shared by the parenthesis balance checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pbc_pkg;

  localparam int LINE_W  = 16;
  localparam int COL_W   = 12;
  localparam int LEVEL_W = 6;
  localparam int COUNT_W = 7;
  localparam int EXTRA_W = 16;

  localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
  localparam logic [COL_W-1:0]   COL_MAX   = '1;
  localparam logic [EXTRA_W-1:0] EXTRA_MAX = '1;

  localparam logic [7:0] CHAR_NL     = 8'd10;
  localparam logic [7:0] CHAR_DQUOTE = 8'd34;
  localparam logic [7:0] CHAR_SQUOTE = 8'd39;
  localparam logic [7:0] CHAR_OPEN   = 8'd40;
  localparam logic [7:0] CHAR_CLOSE  = 8'd41;
  localparam logic [7:0] CHAR_STAR   = 8'd42;
  localparam logic [7:0] CHAR_SLASH  = 8'd47;
  localparam logic [7:0] CHAR_BSLASH = 8'd92;

  localparam logic KIND_OPEN    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_STRING,
    MODE_CHARLIT,
    MODE_LINECMT,
    MODE_BLOCKCMT
  } lex_mode_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_SHOW,
    ST_SUM
  } ctl_state_t;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } char_req_t;

  typedef struct packed {
    logic               kind;
    logic [LINE_W-1:0]  open_line;
    logic [COL_W-1:0]   open_column;
    logic [LEVEL_W-1:0] nest_level;
    logic [COUNT_W-1:0] unclosed_count;
    logic [EXTRA_W-1:0] extra_close_count;
    logic               depth_overflow;
    logic               last;
  } rpt_req_t;

  // Controller to datapath.
  typedef struct packed {
    logic step;        // process the accepted character
    logic walk_start;  // rewind the report index
    logic rd;          // read the stack entry at the report index
    logic walk_next;   // advance the report index
    logic clear;       // return all scan state to its reset value
    logic summary;     // payload shows the summary
  } pbc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk_done;   // report index has reached the open depth
    logic at_top;      // depth is zero
  } pbc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbc_ctrl
// Sequencer: scans characters, then walks the stack and emits the reports.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              char_valid,
  input  wire logic              char_is_last,
  output logic                   char_ready,
  output logic                   rpt_valid,
  input  wire logic              rpt_ready,
  input  wire pbc_pkg::pbc_stat_t stat,
  output pbc_pkg::pbc_cmd_t      cmd
);
  import pbc_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    char_ready = 1'b0;
    rpt_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_RUN: begin
        char_ready = 1'b1;
        if (char_valid) begin
          cmd.step = 1'b1;
          if (char_is_last) begin
            cmd.walk_start = 1'b1;
            state_next     = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (stat.walk_done) begin
          state_next = ST_SUM;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_SHOW;
        end
      end
      ST_SHOW: begin
        rpt_valid = 1'b1;
        if (rpt_ready) begin
          cmd.walk_next = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_SUM: begin
        rpt_valid   = 1'b1;
        cmd.summary = 1'b1;
        if (rpt_ready) begin
          cmd.clear  = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pbc_datapath.sv =====
// ----------------------------------------------------------------------------
// pbc_datapath
// Lexer, position counters, open-parenthesis stack and report payload.
// ----------------------------------------------------------------------------
`default_nettype none

module pbc_datapath #(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        character,
  input  wire pbc_pkg::pbc_cmd_t cmd,
  output pbc_pkg::pbc_stat_t     stat,
  output pbc_pkg::rpt_req_t      rpt_data
);
  import pbc_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(MAX_DEPTH);
  localparam int LW = LINE_W + COL_W;

  lex_mode_t          mode, mode_next;
  logic [7:0]         prev_char, prev_char_next;
  logic               esc_pending, esc_pending_next;
  logic [LINE_W-1:0]  line_cnt, line_cnt_next;
  logic [COL_W-1:0]   col_cnt, col_cnt_next;
  logic [DW-1:0]      depth, depth_next;
  logic [EXTRA_W-1:0] extra, extra_next;
  logic               overflow, overflow_next;
  logic [DW-1:0]      walk_idx;

  logic [LW-1:0]      stack_mem [MAX_DEPTH];
  logic [LW-1:0]      rd_data;
  logic               push_en;

  logic esc;
  logic clear_prev;
  logic is_open;
  logic is_close;

  always_comb begin
    esc        = esc_pending;
    mode_next  = mode;
    clear_prev = 1'b0;
    is_open    = 1'b0;
    is_close   = 1'b0;
    unique case (mode)
      MODE_NORMAL: begin
        priority if (character == CHAR_DQUOTE && !esc) begin
          mode_next = MODE_STRING;
        end else if (character == CHAR_SQUOTE && !esc) begin
          mode_next = MODE_CHARLIT;
        end else if (character == CHAR_SLASH && prev_char == CHAR_SLASH) begin
          mode_next  = MODE_LINECMT;
          clear_prev = 1'b1;
        end else if (character == CHAR_STAR && prev_char == CHAR_SLASH) begin
          mode_next  = MODE_BLOCKCMT;
          clear_prev = 1'b1;
        end else if (character == CHAR_OPEN) begin
          is_open = 1'b1;
        end else if (character == CHAR_CLOSE) begin
          is_close = 1'b1;
        end else begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_STRING: begin
        if ((character == CHAR_DQUOTE || character == CHAR_NL) && !esc) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_CHARLIT: begin
        if ((character == CHAR_SQUOTE || character == CHAR_NL) && !esc) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_LINECMT: begin
        if (character == CHAR_NL && !esc) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_BLOCKCMT: begin
        if (character == CHAR_SLASH && prev_char == CHAR_STAR) begin
          mode_next  = MODE_NORMAL;
          clear_prev = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase

    // Backslashes do not escape anything inside a block comment.
    if (mode_next == MODE_BLOCKCMT && !clear_prev) begin
      esc_pending_next = 1'b0;
    end else begin
      esc_pending_next = (character == CHAR_BSLASH) && !esc;
    end
    prev_char_next = clear_prev ? 8'd0 : character;

    line_cnt_next = line_cnt;
    col_cnt_next  = col_cnt;
    if (character == CHAR_NL) begin
      if (line_cnt != LINE_MAX) begin
        line_cnt_next = line_cnt + LINE_W'(1);
      end
      col_cnt_next = '0;
    end else if (col_cnt != COL_MAX) begin
      col_cnt_next = col_cnt + COL_W'(1);
    end

    push_en       = 1'b0;
    depth_next    = depth;
    extra_next    = extra;
    overflow_next = overflow;
    if (is_open) begin
      if (depth < DW'(MAX_DEPTH)) begin
        push_en    = 1'b1;
        depth_next = depth + DW'(1);
      end else begin
        overflow_next = 1'b1;
      end
    end else if (is_close) begin
      if (depth != '0) begin
        depth_next = depth - DW'(1);
      end else if (extra != EXTRA_MAX) begin
        extra_next = extra + EXTRA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      mode        <= MODE_NORMAL;
      prev_char   <= '0;
      esc_pending <= 1'b0;
      line_cnt    <= '0;
      col_cnt     <= '0;
      depth       <= '0;
      extra       <= '0;
      overflow    <= 1'b0;
    end else if (cmd.step) begin
      mode        <= mode_next;
      prev_char   <= prev_char_next;
      esc_pending <= esc_pending_next;
      line_cnt    <= line_cnt_next;
      col_cnt     <= col_cnt_next;
      depth       <= depth_next;
      extra       <= extra_next;
      overflow    <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.walk_start) begin
      walk_idx <= '0;
    end else if (cmd.walk_next) begin
      walk_idx <= walk_idx + DW'(1);
    end
  end

  // Stack of open positions: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.step && push_en) begin
      stack_mem[depth[AW-1:0]] <= {line_cnt, col_cnt};
    end
    if (cmd.rd) begin
      rd_data <= stack_mem[walk_idx[AW-1:0]];
    end
  end

  assign stat.walk_done = (walk_idx >= depth);
  assign stat.at_top    = (depth == '0);

  always_comb begin
    rpt_data                = '0;
    rpt_data.depth_overflow = overflow;
    if (cmd.summary) begin
      rpt_data.kind              = KIND_SUMMARY;
      rpt_data.unclosed_count    = COUNT_W'(depth);
      rpt_data.extra_close_count = extra;
      rpt_data.last              = 1'b1;
    end else begin
      rpt_data.kind        = KIND_OPEN;
      rpt_data.open_line   = rd_data[LW-1:COL_W];
      rpt_data.open_column = rd_data[COL_W-1:0];
      rpt_data.nest_level  = LEVEL_W'(walk_idx);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/paren_balance_checker_unit.sv =====
// Character requests are accepted one per cycle with no gaps while the block
// is scanning, and each is processed as it is accepted.
// After the last character, each unclosed-open report needs a stack read and
// is then held on the output until taken; the summary follows the last one,
// and no character is taken during this walk.
// Synchronous reset clears lexer, counters, depth and flags; the stack is not.
// ----------------------------------------------------------------------------
// paren_balance_checker_unit
// Comment-aware parenthesis balance checker for C source text.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module paren_balance_checker_unit #(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               char_valid,
  output logic                    char_ready,
  input  wire pbc_pkg::char_req_t char_data,
  output logic                    rpt_valid,
  input  wire logic               rpt_ready,
  output pbc_pkg::rpt_req_t       rpt_data
);
  import pbc_pkg::*;

  // The controller only issues commands; the datapath owns all scan state
  // and the stack of open positions. The stack depth is the one sizing knob.
  pbc_cmd_t  cmd;
  pbc_stat_t stat;

  // Handshake events watched by the assertions below.
  logic last_taken;
  logic sum_taken;

  assign last_taken = char_valid && char_ready && char_data.is_last;
  assign sum_taken  = rpt_valid && rpt_ready && rpt_data.last;

  // The controller stays in its scan state, ready every cycle, until the
  // character marked last arrives. It then steps through the stack from the
  // outermost entry inward and finishes with the summary request.
  pbc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_is_last (char_data.is_last),
    .char_ready   (char_ready),
    .rpt_valid    (rpt_valid),
    .rpt_ready    (rpt_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // The datapath holds the lexer mode, previous character, escape flag, line
  // and column counters, depth, extra-close counter and overflow flag. The
  // summary request clears them all, so the next text starts from scratch.
  pbc_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .character (char_data.character),
    .cmd       (cmd),
    .stat      (stat),
    .rpt_data  (rpt_data)
  );

  // Scanning and reporting never overlap.
  `PBC_ASSERT_NOW(a_no_scan_while_report, clk, rst, rpt_valid, !char_ready, "scan during report")

  // The last character starts the report walk at once.
  `PBC_ASSERT_NEXT(a_walk_start, clk, rst, last_taken, !char_ready && !rpt_valid, "walk late")

  // Once the summary is taken, the block is back to scanning.
  `PBC_ASSERT_NEXT(a_scan_after_sum, clk, rst, sum_taken, char_ready && stat.at_top, "not back")

endmodule

`default_nettype wire

// ===== dv/tb_paren_balance_checker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_paren_balance_checker_unit
// Self-checking bench for the comment-aware parenthesis balance checker. A
// driver streams C-like text one character request at a time and a monitor
// takes the report requests. A scoreboard model of the lexer and of the open
// stack predicts every report, and each one is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_paren_balance_checker_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import pbc_pkg::*;

  localparam int STACK_DEPTH   = 32;
  localparam int RANDOM_CHARS  = 300;
  localparam int SETTLE_CYCLES = 16;

  // One character request waiting to be sent, with the idle cycles that go
  // in front of it and whether the sender must first see all reports back.
  typedef struct {
    char_req_t   req;
    int unsigned gap;
    bit          drain;
  } char_slot_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_ready;
  char_req_t char_data = '0;
  logic      rpt_valid;
  logic      rpt_ready = 1'b0;
  rpt_req_t  rpt_data;

  char_slot_t pending_chars[$];
  rpt_req_t   expected_reports[$];
  int         errors = 0;

  // Scoreboard copy of the scanner state.
  lex_mode_t          scan_mode;
  logic [7:0]         last_char;
  logic               escape_armed;
  logic [LINE_W-1:0]  cur_line;
  logic [COL_W-1:0]   cur_col;
  int unsigned        open_depth;
  logic [LINE_W-1:0]  open_line_at[STACK_DEPTH];
  logic [COL_W-1:0]   open_col_at[STACK_DEPTH];
  logic [EXTRA_W-1:0] extra_close_total;
  logic               nest_overflow;

  // Driver and monitor bookkeeping.
  int unsigned gap_left = 0;
  bit          gap_loaded = 1'b0;
  int unsigned stall_left = 0;
  bit          calm_rx = 1'b0;
  rpt_req_t    want;

  paren_balance_checker_unit #(
    .MAX_DEPTH(STACK_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_data (char_data),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt_data  (rpt_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Scoreboard model
  // --------------------------------------------------------------------------

  // Return the scanner to the state it holds after reset or after a report.
  task automatic clear_scan();
    scan_mode         = MODE_NORMAL;
    last_char         = 8'd0;
    escape_armed      = 1'b0;
    cur_line          = '0;
    cur_col           = '0;
    open_depth        = 0;
    extra_close_total = '0;
    nest_overflow     = 1'b0;
  endtask

  // Advance the scanner by one accepted character. When the character closes
  // the text, queue one report per unclosed open, outermost first, and then
  // the summary.
  task automatic scan_char(input char_req_t r);
    logic [7:0]  c;
    logic        esc;
    logic [7:0]  prev;
    logic        consumed;
    int unsigned i;
    rpt_req_t    rep;
    c        = r.character;
    esc      = escape_armed;
    prev     = last_char;
    consumed = 1'b0;
    case (scan_mode)
      MODE_NORMAL: begin
        if (c == CHAR_DQUOTE && !esc) begin
          scan_mode = MODE_STRING;
        end else if (c == CHAR_SQUOTE && !esc) begin
          scan_mode = MODE_CHARLIT;
        end else if (c == CHAR_SLASH && prev == CHAR_SLASH) begin
          scan_mode = MODE_LINECMT;
          consumed  = 1'b1;
        end else if (c == CHAR_STAR && prev == CHAR_SLASH) begin
          scan_mode = MODE_BLOCKCMT;
          consumed  = 1'b1;
        end else if (c == CHAR_OPEN) begin
          // A full stack drops the open and only raises the overflow flag.
          if (open_depth < STACK_DEPTH) begin
            open_line_at[open_depth] = cur_line;
            open_col_at[open_depth]  = cur_col;
            open_depth++;
          end else begin
            nest_overflow = 1'b1;
          end
        end else if (c == CHAR_CLOSE) begin
          if (open_depth > 0) begin
            open_depth--;
          end else if (extra_close_total != EXTRA_MAX) begin
            extra_close_total++;
          end
        end
      end
      MODE_STRING: begin
        if ((c == CHAR_DQUOTE || c == CHAR_NL) && !esc) scan_mode = MODE_NORMAL;
      end
      MODE_CHARLIT: begin
        if ((c == CHAR_SQUOTE || c == CHAR_NL) && !esc) scan_mode = MODE_NORMAL;
      end
      MODE_LINECMT: begin
        if (c == CHAR_NL && !esc) scan_mode = MODE_NORMAL;
      end
      default: begin
        if (c == CHAR_SLASH && prev == CHAR_STAR) begin
          scan_mode = MODE_NORMAL;
          consumed  = 1'b1;
        end
      end
    endcase

    // Backslashes carry no meaning inside a block comment.
    if (scan_mode == MODE_BLOCKCMT && !consumed) begin
      escape_armed = 1'b0;
    end else begin
      escape_armed = (c == CHAR_BSLASH && !esc);
    end
    // A character that completes a delimiter cannot start the next one.
    last_char = consumed ? 8'd0 : c;

    if (c == CHAR_NL) begin
      if (cur_line != LINE_MAX) cur_line++;
      cur_col = '0;
    end else if (cur_col != COL_MAX) begin
      cur_col++;
    end

    if (r.is_last) begin
      for (i = 0; i < open_depth; i++) begin
        rep                = '0;
        rep.kind           = KIND_OPEN;
        rep.open_line      = open_line_at[i];
        rep.open_column    = open_col_at[i];
        rep.nest_level     = LEVEL_W'(i);
        rep.depth_overflow = nest_overflow;
        expected_reports.push_back(rep);
      end
      rep                   = '0;
      rep.kind              = KIND_SUMMARY;
      rep.unclosed_count    = COUNT_W'(open_depth);
      rep.extra_close_count = extra_close_total;
      rep.depth_overflow    = nest_overflow;
      rep.last              = 1'b1;
      expected_reports.push_back(rep);
      clear_scan();
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: report field %s mismatch, expected %0d, actual %0d",
               $time, name, exp_val, act_val);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // A calm character goes out without idle cycles in front of it.
  task automatic queue_char(input logic [7:0] c, input bit is_last, input bit calm,
                            input bit drain);
    char_slot_t slot;
    slot.req.character = c;
    slot.req.is_last   = is_last;
    slot.gap           = calm ? 0 : $urandom_range(0, 4);
    slot.drain         = drain;
    pending_chars.push_back(slot);
  endtask

  // Send a whole text; its final character marks the end.
  task automatic queue_text(input string s, input bit drain);
    int i;
    for (i = 0; i < s.len(); i++) begin
      queue_char(s[i], i == s.len() - 1, 1'b0, drain && i == 0);
    end
  endtask

  // Draw one character, weighted toward the ones the lexer cares about.
  function automatic logic [7:0] pick_char(input int unsigned open_weight);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < open_weight) return CHAR_OPEN;
    roll = $urandom_range(0, 99);
    if (roll < 22) return CHAR_CLOSE;
    if (roll < 30) return CHAR_DQUOTE;
    if (roll < 36) return CHAR_SQUOTE;
    if (roll < 48) return CHAR_SLASH;
    if (roll < 56) return CHAR_STAR;
    if (roll < 63) return CHAR_BSLASH;
    if (roll < 73) return CHAR_NL;
    if (roll < 90) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents character requests from the pending queue. A new
  // request is loaded only when the current one has been taken, so valid
  // never drops while a request is outstanding. Each accepted request is
  // handed to the scoreboard at the edge where it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      gap_loaded  = 1'b0;
      gap_left    = 0;
      clear_scan();
    end else begin
      if (char_valid && char_ready) scan_char(char_data);
      if (!char_valid || char_ready) begin
        if (pending_chars.size() == 0) begin
          char_valid <= 1'b0;
        end else begin
          if (!gap_loaded) begin
            gap_left   = pending_chars[0].gap;
            gap_loaded = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
            char_valid <= 1'b0;
          end else if (pending_chars[0].drain && expected_reports.size() != 0) begin
            // Hold off until every report of the earlier texts is back.
            char_valid <= 1'b0;
          end else begin
            char_data  <= pending_chars[0].req;
            char_valid <= 1'b1;
            void'(pending_chars.pop_front());
            gap_loaded = 1'b0;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes report requests with random back-pressure and checks each
  // against the oldest prediction. After a summary it decides whether the
  // next stretch runs without stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rpt_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rpt_valid && rpt_ready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected report, expected none, actual kind %0d line %0d col %0d",
                   $time, rpt_data.kind, rpt_data.open_line, rpt_data.open_column);
        end else begin
          want = expected_reports.pop_front();
          check_field("kind", want.kind, rpt_data.kind);
          check_field("open_line", want.open_line, rpt_data.open_line);
          check_field("open_column", want.open_column, rpt_data.open_column);
          check_field("nest_level", want.nest_level, rpt_data.nest_level);
          check_field("unclosed_count", want.unclosed_count, rpt_data.unclosed_count);
          check_field("extra_close_count", want.extra_close_count,
                      rpt_data.extra_close_count);
          check_field("depth_overflow", want.depth_overflow, rpt_data.depth_overflow);
          check_field("last", want.last, rpt_data.last);
        end
        if (rpt_data.last) calm_rx = ($urandom_range(0, 3) == 0);
        stall_left = calm_rx ? 0 : $urandom_range(0, 4);
      end else if (!rpt_valid && !calm_rx && stall_left == 0 &&
                   $urandom_range(0, 3) == 0) begin
        // Drop ready now and then while idle, so the first report of a walk
        // can also meet a stall.
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        rpt_ready <= 1'b0;
      end else begin
        rpt_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int          i;
    int          len;
    int unsigned random_chars;
    int unsigned open_weight;
    bit          calm;
    bit          drain;

    // Literals hide parentheses, an escaped quote stays inside its string,
    // and a parenthesis inside a character literal does not count.
    queue_text("((\"(\\\")\"')'/*(*/)\n)", 1'b0);
    // A backslash before a newline continues a line comment; the slash of
    // a block comment opener does not also close it.
    queue_text("//c\\\n(\n(/*/)*/)x", 1'b0);
    // Closes at depth zero are extra; a newline ends an open string; an
    // escaped quote keeps a character literal open. Sent only once all
    // earlier reports are back.
    queue_text(")))\"ab\n('\\'(", 1'b1);
    // An escaped newline stays inside a string; a backslash in a block
    // comment escapes nothing.
    queue_text("\"a\\\nb\"(/*\\*/(", 1'b0);
    // Extremes of the character byte.
    queue_char(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_char(8'h00, 1'b1, 1'b0, 1'b0);
    // One open past the stack depth: a full set of reports and overflow.
    for (i = 0; i <= STACK_DEPTH; i++) begin
      queue_char(CHAR_OPEN, i == STACK_DEPTH, 1'b0, 1'b0);
    end

    // Random texts: mostly short, some long, some heavy on opens so the
    // stack fills, some sent without gaps.
    random_chars = 0;
    while (random_chars < RANDOM_CHARS) begin
      len         = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90)
                                                : $urandom_range(1, 25);
      calm        = ($urandom_range(0, 3) == 0);
      drain       = ($urandom_range(0, 14) == 0);
      open_weight = ($urandom_range(0, 4) == 0) ? 55 : 18;
      for (i = 0; i < len; i++) begin
        queue_char(pick_char(open_weight), i == len - 1, calm, drain && i == 0);
      end
      random_chars += len;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Sample away from the active edge so the driver and monitor updates
    // of this cycle are settled.
    do @(negedge clk);
    while (pending_chars.size() != 0 || char_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("tb_paren_balance_checker_unit: done, clean");
    end else begin
      $display("tb_paren_balance_checker_unit: done, errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("tb_paren_balance_checker_unit: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
